[sv/attack_decay_envelope_defines.svh]
// Assertion macros shared by the envelope RTL.
`ifndef ATTACK_DECAY_ENVELOPE_DEFINES_SVH
`define ATTACK_DECAY_ENVELOPE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ADE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ADE_ASSERT(lbl, clk, rst_n, prop, msg)
`define ADE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/ade_pkg.sv]
package ade_pkg;

    localparam int EXP_SQ_DEF     = 8;
    localparam int LEVEL_BITS_DEF = 24;
    localparam int CURVE_FRAC     = 36;
    localparam int LVL_W          = 24;
    localparam int CNT_W          = 25;
    localparam int CURVE_W        = 15;
    localparam int STAGE_W        = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_W          = 24;
    localparam int OP_W           = 64;

    typedef logic [STAGE_W-1:0] t_seg;
    localparam t_seg SEG_IDLE = 2'd0;
    localparam t_seg SEG_ATT  = 2'd1;
    localparam t_seg SEG_DEC  = 2'd2;
    localparam t_seg SEG_RSV  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd4;

    localparam logic [23:0]        ATT_RST   = 24'd2400;
    localparam logic [23:0]        DEC_RST   = 24'd2400;
    localparam logic signed [23:0] HIGH_RST  = 24'sd4194304;
    localparam logic signed [23:0] LEVEL_RST = 24'sd419;
    localparam logic signed [23:0] ONE_Q22   = 24'sd4194304;

    localparam logic signed [63:0] LVL_MAX64 = 64'sd8388607;
    localparam logic signed [63:0] LVL_MIN64 = -64'sd8388608;
    localparam logic [63:0] EXP_ONE    = 64'h0000_0000_4000_0000;
    localparam logic [63:0] EXP_CAP    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] XPOS_LIMIT = 64'd67108864;
    localparam logic [63:0] SAT_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0] TICK_MAX = 25'h1FF_FFFF;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic signed [LVL_W-1:0] clamp_lvl(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > LVL_MAX64) c = LVL_MAX64;
        if (v < LVL_MIN64) c = LVL_MIN64;
        return c[LVL_W-1:0];
    endfunction

endpackage

[sv/ade_in_if.sv]
interface ade_in_if;
    logic valid;
    logic ready;
    logic retrigger;
    modport source(output valid, output retrigger, input ready);
    modport sink(input valid, input retrigger, output ready);
endinterface

[sv/ade_out_if.sv]
interface ade_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ade_pkg::LVL_W-1:0]    sample_out;
    logic [ade_pkg::STAGE_W-1:0]         stage;
    modport source(output valid, output sample_out, output stage, input ready);
    modport sink(input valid, input sample_out, input stage, output ready);
endinterface

[sv/ade_mul.sv]
module ade_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ade_pkg::OP_W-1:0]    i_a,
    input  logic [ade_pkg::OP_W-1:0]    i_b,
    output ade_pkg::t_unit_sts          o_sts,
    output logic [2*ade_pkg::OP_W-1:0]  o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  w_a_half;
    logic [31:0]  w_b_half;

    assign w_a_half = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign w_b_half = r_cnt[1] ? r_b[63:32] : r_b[31:0];

    // one 32x32 partial product per cycle, accumulated in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= 128'd0;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp <= 64'(w_a_half) * 64'(w_b_half);
                    r_sh <= 2'({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]});
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + ({64'd0, r_pp} << {r_sh, 5'd0});
                end
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

[sv/ade_div.sv]
module ade_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ade_pkg::OP_W-1:0]  i_dividend,
    input  logic [ade_pkg::OP_W-1:0]  i_divisor,
    output ade_pkg::t_unit_sts        o_sts,
    output logic [ade_pkg::OP_W-1:0]  o_quo
);

    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_sh;
    logic [64:0] w_tr;

    assign w_sh = {r_rem, r_quo[63]};
    assign w_tr = w_sh - {1'b0, r_dvs};

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= 64'd0;
                r_dvs  <= i_divisor;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_tr[64]) begin
                    r_rem <= w_tr[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

[sv/attack_decay_envelope.sv]
// Attack/decay envelope generator, one request per audio sample tick.
// i_in carries the retrigger bit; o_out returns the scaled level held
// before this tick (sample_out) and the segment after it (stage).
// Lengths, curve and output span are set on the i_cfg_* write port, which
// the user must write only while the block is idle; the block itself does
// not enforce this. Index 0..4 is attack, decay, curve, low, high. Each
// request runs through a sequencer that drives one 64-bit shift/subtract
// divider and one 64x64 multiplier built from four 32x32 partial products.
// A linear tick uses two multiplies, plus a divide on segment entry; a curved
// tick a divide, an exponential and two multiplies, plus an exponential and a
// divide on entry, where the exponential costs up to eight multiplier passes.
// i_in.ready is high only between requests. A finished result sits in the
// output register while the next request is taken; if o_out is stalled when
// the following result is done, the sequencer holds until it drains.
// Synchronous reset returns to idle with level 0.0001 and forces a slope
// recompute on the first request.
`include "attack_decay_envelope_defines.svh"

module attack_decay_envelope #(
    parameter int EXP_SQUARINGS = ade_pkg::EXP_SQ_DEF,
    parameter int LEVEL_BITS    = ade_pkg::LEVEL_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ade_in_if.sink                           i_in,
    ade_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [ade_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ade_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SQ_W = $clog2(EXP_SQUARINGS + 1);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PREP     = 4'd1;
    localparam logic [3:0] ST_SLOPE_WT = 4'd2;
    localparam logic [3:0] ST_EXP_INIT = 4'd3;
    localparam logic [3:0] ST_EXP      = 4'd4;
    localparam logic [3:0] ST_EXP_WT   = 4'd5;
    localparam logic [3:0] ST_EXP_RET  = 4'd6;
    localparam logic [3:0] ST_TICK     = 4'd7;
    localparam logic [3:0] ST_XDIV_WT  = 4'd8;
    localparam logic [3:0] ST_LVL_WT   = 4'd9;
    localparam logic [3:0] ST_OUT_WT   = 4'd10;
    localparam logic [3:0] ST_WRITE    = 4'd11;

    // configuration
    logic [23:0]        r_att;
    logic [23:0]        r_dec;
    logic signed [14:0] r_curve;
    logic signed [23:0] r_low;
    logic signed [23:0] r_high;

    // envelope state
    logic signed [23:0] r_level;
    logic signed [23:0] r_start;
    logic signed [63:0] r_slope;
    logic [24:0]        r_cnt;
    ade_pkg::t_seg      r_seg;
    logic               r_ent;

    // sequencer working registers
    logic [3:0]         r_state;
    logic signed [23:0] r_held;
    logic signed [25:0] r_diff;
    logic               r_neg;
    logic signed [27:0] r_x;
    logic [63:0]        r_m;
    logic [SQ_W-1:0]    r_sqn;
    logic               r_ret;
    logic signed [63:0] r_d20;
    logic signed [23:0] r_res;
    logic [63:0]        r_opa;
    logic [63:0]        r_opb;
    logic               r_mul_go;
    logic               r_div_go;

    // output register
    logic               r_ov;
    logic signed [23:0] r_osample;
    ade_pkg::t_seg      r_ostage;
    logic               w_load;

    ade_pkg::t_unit_sts w_mul_sts;
    ade_pkg::t_unit_sts w_div_sts;
    logic [127:0]       w_mul_p;
    logic [63:0]        w_div_q;

    logic [23:0]        c_t;
    logic signed [23:0] c_beg;
    logic signed [23:0] c_end;
    logic signed [25:0] c_diff;
    logic [25:0]        c_diff_mag;
    logic [25:0]        c_rdiff_mag;
    logic [24:0]        c_n;
    logic signed [40:0] c_cn;
    logic [40:0]        c_cn_mag;
    logic [63:0]        c_slope_mag;
    logic [63:0]        c_d20_mag;
    logic signed [39:0] c_xs;
    logic signed [39:0] c_y;
    logic [39:0]        c_y_mag;
    logic [63:0]        c_qx;
    logic signed [27:0] c_x;
    logic [6:0]         c_shift;
    logic               c_sat;
    logic signed [63:0] c_satv;
    logic signed [63:0] c_pv;
    logic signed [63:0] c_v;
    logic signed [23:0] c_lvl;
    logic signed [23:0] c_res;
    logic signed [63:0] c_d20_new;
    logic signed [24:0] c_hl;
    logic [24:0]        c_hl_mag;
    logic [23:0]        c_held_mag;

    always_comb begin
        c_t = 24'd1;
        if (r_seg == ade_pkg::SEG_ATT) c_t = r_att;
        if (r_seg == ade_pkg::SEG_DEC) c_t = r_dec;
        if (c_t == 24'd0) c_t = 24'd1;

        c_beg = 24'sd0;
        c_end = 24'sd0;
        if (r_seg == ade_pkg::SEG_ATT) begin
            c_beg = r_level;
            c_end = ade_pkg::ONE_Q22;
        end
        if (r_seg == ade_pkg::SEG_DEC) c_beg = ade_pkg::ONE_Q22;
        c_diff      = 26'(c_end) - 26'(c_beg);
        c_diff_mag  = c_diff[25] ? 26'(-c_diff) : 26'(c_diff);
        c_rdiff_mag = r_diff[25] ? 26'(-r_diff) : 26'(r_diff);

        c_n      = (r_cnt < ade_pkg::TICK_MAX) ? r_cnt + 25'd1 : ade_pkg::TICK_MAX;
        c_cn     = 41'(r_curve) * 41'($signed({1'b0, c_n}));
        c_cn_mag = c_cn[40] ? 41'(-c_cn) : 41'(c_cn);

        c_slope_mag = r_slope[63] ? 64'(-r_slope) : 64'(r_slope);
        c_d20_mag   = r_d20[63] ? 64'(-r_d20) : 64'(r_d20);

        // exponential base: 1 + x/2^squarings in Q.30
        c_xs    = 40'(r_x) <<< 10;
        c_y     = 40'sd1073741824 + (c_xs >>> EXP_SQUARINGS);
        c_y_mag = c_y[39] ? 40'(-c_y) : 40'(c_y);

        c_qx = (w_div_q > ade_pkg::XPOS_LIMIT) ? ade_pkg::XPOS_LIMIT : w_div_q;
        c_x  = r_neg ? -$signed(c_qx[27:0]) : $signed(c_qx[27:0]);

        // saturating product with floor shift
        c_shift = (r_curve == 15'sd0) ? 7'(LEVEL_BITS) : 7'(ade_pkg::CURVE_FRAC);
        c_sat   = |w_mul_p[127:63];
        c_satv  = $signed(ade_pkg::SAT_MAX >> c_shift);
        c_pv    = r_neg ? -$signed(w_mul_p[63:0]) : $signed(w_mul_p[63:0]);
        c_v     = c_sat ? (r_neg ? -c_satv : c_satv) : (c_pv >>> c_shift);
        c_lvl   = ade_pkg::clamp_lvl(64'(r_start) + c_v);
        c_res   = ade_pkg::clamp_lvl((c_pv >>> 22) + 64'(r_low));

        c_d20_new = $signed(ade_pkg::EXP_ONE - r_m) >>> 10;

        c_hl       = 25'(r_high) - 25'(r_low);
        c_hl_mag   = c_hl[24] ? 25'(-c_hl) : 25'(c_hl);
        c_held_mag = r_held[23] ? 24'(-r_held) : 24'(r_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att   <= ade_pkg::ATT_RST;
            r_dec   <= ade_pkg::DEC_RST;
            r_curve <= 15'sd0;
            r_low   <= 24'sd0;
            r_high  <= ade_pkg::HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ade_pkg::CFG_ATTACK: r_att   <= i_cfg_data;
                ade_pkg::CFG_DECAY:  r_dec   <= i_cfg_data;
                ade_pkg::CFG_CURVE:  r_curve <= $signed(i_cfg_data[14:0]);
                ade_pkg::CFG_LOW:    r_low   <= $signed(i_cfg_data);
                ade_pkg::CFG_HIGH:   r_high  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_level  <= ade_pkg::LEVEL_RST;
            r_start  <= 24'sd0;
            r_slope  <= 64'sd0;
            r_cnt    <= 25'd0;
            r_seg    <= ade_pkg::SEG_IDLE;
            r_ent    <= 1'b1;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            r_ret    <= 1'b0;
            r_sqn    <= '0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.retrigger) begin
                            r_seg <= ade_pkg::SEG_ATT;
                            r_ent <= 1'b1;
                        end
                        r_held  <= r_level;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_diff <= c_diff;
                    if (r_ent) begin
                        r_cnt <= 25'd0;
                        r_ent <= 1'b0;
                        if (r_curve == 15'sd0) begin
                            r_start  <= r_level;
                            r_opa    <= 64'(c_diff_mag) << LEVEL_BITS;
                            r_opb    <= 64'(c_t);
                            r_neg    <= c_diff[25];
                            r_div_go <= 1'b1;
                            r_state  <= ST_SLOPE_WT;
                        end else begin
                            r_start <= c_beg;
                            r_x     <= 28'(r_curve) <<< 10;
                            r_ret   <= 1'b0;
                            r_state <= ST_EXP_INIT;
                        end
                    end else begin
                        r_state <= ST_TICK;
                    end
                end
                ST_SLOPE_WT: begin
                    if (w_div_sts.done) begin
                        r_slope <= r_neg ? -$signed(w_div_q) : $signed(w_div_q);
                        r_state <= ST_TICK;
                    end
                end
                ST_EXP_INIT: begin
                    r_m     <= 64'(c_y_mag);
                    r_sqn   <= '0;
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    if (r_sqn == SQ_W'(EXP_SQUARINGS)) begin
                        r_d20   <= c_d20_new;
                        r_state <= ST_EXP_RET;
                    end else if (r_m[63:32] != 32'd0) begin
                        // base too large: pin at the cap
                        r_m   <= ade_pkg::EXP_CAP;
                        r_sqn <= r_sqn + SQ_W'(1);
                    end else begin
                        r_opa    <= r_m;
                        r_opb    <= r_m;
                        r_mul_go <= 1'b1;
                        r_state  <= ST_EXP_WT;
                    end
                end
                ST_EXP_WT: begin
                    if (w_mul_sts.done) begin
                        r_m     <= {30'd0, w_mul_p[63:30]};
                        r_sqn   <= r_sqn + SQ_W'(1);
                        r_state <= ST_EXP;
                    end
                end
                ST_EXP_RET: begin
                    if (!r_ret) begin
                        if (r_d20 == 64'sd0) begin
                            r_slope <= 64'sd0;
                            r_state <= ST_TICK;
                        end else begin
                            r_opa    <= 64'(c_rdiff_mag) << ade_pkg::CURVE_FRAC;
                            r_opb    <= c_d20_mag;
                            r_neg    <= r_diff[25] ^ r_d20[63];
                            r_div_go <= 1'b1;
                            r_state  <= ST_SLOPE_WT;
                        end
                    end else begin
                        r_opa    <= c_slope_mag;
                        r_opb    <= c_d20_mag;
                        r_neg    <= r_slope[63] ^ r_d20[63];
                        r_mul_go <= 1'b1;
                        r_state  <= ST_LVL_WT;
                    end
                end
                ST_TICK: begin
                    r_cnt <= c_n;
                    if (r_curve == 15'sd0) begin
                        r_opa    <= c_slope_mag;
                        r_opb    <= 64'(c_n);
                        r_neg    <= r_slope[63];
                        r_mul_go <= 1'b1;
                        r_state  <= ST_LVL_WT;
                    end else begin
                        r_opa    <= 64'(c_cn_mag) << 10;
                        r_opb    <= 64'(c_t);
                        r_neg    <= c_cn[40];
                        r_div_go <= 1'b1;
                        r_state  <= ST_XDIV_WT;
                    end
                end
                ST_XDIV_WT: begin
                    if (w_div_sts.done) begin
                        r_x     <= c_x;
                        r_ret   <= 1'b1;
                        r_state <= ST_EXP_INIT;
                    end
                end
                ST_LVL_WT: begin
                    if (w_mul_sts.done) begin
                        r_level <= c_lvl;
                        // count past the length: advance the segment
                        if (r_seg != ade_pkg::SEG_IDLE && r_cnt > 25'(c_t)) begin
                            r_seg <= (r_seg == ade_pkg::SEG_ATT) ? ade_pkg::SEG_DEC
                                                                 : ade_pkg::SEG_IDLE;
                            r_ent <= 1'b1;
                        end
                        r_opa    <= 64'(c_held_mag);
                        r_opb    <= 64'(c_hl_mag);
                        r_neg    <= r_held[23] ^ c_hl[24];
                        r_mul_go <= 1'b1;
                        r_state  <= ST_OUT_WT;
                    end
                end
                ST_OUT_WT: begin
                    if (w_mul_sts.done) begin
                        r_res   <= c_res;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (w_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign w_load = (r_state == ST_WRITE) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_osample <= r_res;
            r_ostage  <= r_seg;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_osample;
    assign o_out.stage      = r_ostage;

    ade_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_sts   (w_mul_sts),
        .o_prod  (w_mul_p)
    );

    ade_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_opa),
        .i_divisor  (r_opb),
        .o_sts      (w_div_sts),
        .o_quo      (w_div_q)
    );

    `ADE_ASSERT_IMP(a_idle_units_quiet, i_clk, i_rst_n, i_in.ready, !(w_mul_sts.busy || w_div_sts.busy), "arithmetic unit busy while idle")
    `ADE_ASSERT(a_units_exclusive, i_clk, i_rst_n, !(w_mul_sts.busy && w_div_sts.busy), "multiplier and divider busy together")
    `ADE_ASSERT(a_accept_drops_ready, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "ready held after accept")
    `ADE_ASSERT_IMP(a_stage_code, i_clk, i_rst_n, o_out.valid, o_out.stage != ade_pkg::SEG_RSV, "reserved stage code")

endmodule
